FILE: rtl/core/ppq_pkg.sv
// shared types, codes and defaults of the priority ready queue scheduler
package ppq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;
  localparam int LEVELS_DEF      = 5;

  localparam int PRIO_W    = 3;
  localparam int TASK_ID_W = 8;
  localparam int STATUS_W  = 2;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TERM = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_PRIO = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic add;
    logic term;
    logic pop_done;
  } ppq_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pend_free;
    logic any_queued;
  } ppq_stat_t;

endpackage

FILE: rtl/core/preemptive_priority_ready_queues_core.sv
// top level of the preemptive priority scheduler with per-level ready queues
//
// channel  dir  signals                              content
// s_axis   in   tvalid tready tdata[15:0] tuser[0]   add or terminate request
// m_axis   out  tvalid tready tdata[15:0]            running task and status
//
// an add request is handled in the idle state; a terminate with a task queued also
// passes through the pop state (registered read of the id store), other terminates do not.
// a finished result waits in a pending stage while the output register is held,
// so one request is taken while the previous result is still stalled.
// reset clears the queue pointers, counts and running slot; the id store needs
// no clearing pass, only entries that were pushed are ever read.
module preemptive_priority_ready_queues_core #(
  parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ppq_pkg::ID_BITS_DEF,
  parameter int LEVELS      = ppq_pkg::LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // task_priority[2:0], task_id[10:3], zero pad
  input  logic [0:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // running_valid[0], running_id[8:1],
                                      // running_priority[11:9], status[13:12], zero pad
);

  ppq_pkg::ppq_cmd_t  cmd;
  ppq_pkg::ppq_stat_t stat;

  logic                          running_valid;
  logic [ppq_pkg::TASK_ID_W-1:0] running_id;
  logic [ppq_pkg::PRIO_W-1:0]    running_priority;
  logic [ppq_pkg::STATUS_W-1:0]  status;

  ppq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser[0]),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  ppq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .LEVELS      (LEVELS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .task_priority_i    (s_axis_tdata[2:0]),
    .task_id_i          (s_axis_tdata[10:3]),
    .out_ready_i        (m_axis_tready),
    .stat_o             (stat),
    .out_valid_o        (m_axis_tvalid),
    .running_valid_o    (running_valid),
    .running_id_o       (running_id),
    .running_priority_o (running_priority),
    .status_o           (status)
  );

  assign m_axis_tdata = {2'b00, status, running_priority, running_id, running_valid};

endmodule

FILE: rtl/core/ppq_ctrl.sv
// controller state machine of the priority ready queue scheduler
module ppq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               action_i,
  input  ppq_pkg::ppq_stat_t stat_i,
  output logic               in_ready_o,
  output ppq_pkg::ppq_cmd_t  cmd_o
);

  ppq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ppq_pkg::ST_IDLE: begin
        // a terminate with a queued task moves to the pop state to wait for the store read
        if (in_valid_i && stat_i.pend_free && (action_i == ppq_pkg::ACT_TERM) &&
            stat_i.any_queued) begin
          state_d = ppq_pkg::ST_POP;
        end
      end
      ppq_pkg::ST_POP: begin
        state_d = ppq_pkg::ST_IDLE;
      end
      default: begin
        state_d = ppq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ppq_pkg::ST_IDLE: begin
        in_ready_o     = stat_i.pend_free;
        cmd_o.add      = in_valid_i && stat_i.pend_free && (action_i == ppq_pkg::ACT_ADD);
        cmd_o.term     = in_valid_i && stat_i.pend_free && (action_i == ppq_pkg::ACT_TERM);
      end
      ppq_pkg::ST_POP: begin
        cmd_o.pop_done = 1'b1;
      end
      default: begin
        in_ready_o     = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/ppq_datapath.sv
// ready queues, id store, running slot and result registers of the scheduler
module ppq_datapath #(
  parameter int QUEUE_DEPTH = ppq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ppq_pkg::ID_BITS_DEF,
  parameter int LEVELS      = ppq_pkg::LEVELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ppq_pkg::ppq_cmd_t              cmd_i,
  input  logic [ppq_pkg::PRIO_W-1:0]     task_priority_i,
  input  logic [ppq_pkg::TASK_ID_W-1:0]  task_id_i,
  input  logic                           out_ready_i,
  output ppq_pkg::ppq_stat_t             stat_o,
  output logic                           out_valid_o,
  output logic                           running_valid_o,
  output logic [ppq_pkg::TASK_ID_W-1:0]  running_id_o,
  output logic [ppq_pkg::PRIO_W-1:0]     running_priority_o,
  output logic [ppq_pkg::STATUS_W-1:0]   status_o
);

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic [ppq_pkg::PRIO_W:0] LEVELS_C   = (ppq_pkg::PRIO_W + 1)'(LEVELS);
  localparam logic [CNT_W-1:0]         FULL_C     = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]         PTR_LAST_C = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [ADDR_W-1:0]        DEPTH_C    = ADDR_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_LAST_C) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  logic [ID_BITS-1:0] mem [MEM_DEPTH];
  logic [ID_BITS-1:0] rdata_q;

  logic [PTR_W-1:0] head_q [LEVELS];
  logic [PTR_W-1:0] head_d [LEVELS];
  logic [PTR_W-1:0] tail_q [LEVELS];
  logic [PTR_W-1:0] tail_d [LEVELS];
  logic [CNT_W-1:0] cnt_q  [LEVELS];
  logic [CNT_W-1:0] cnt_d  [LEVELS];

  logic               run_valid_q, run_valid_d;
  logic [ID_BITS-1:0] run_id_q, run_id_d;
  logic [LVL_W-1:0]   run_prio_q, run_prio_d;
  logic [LVL_W-1:0]   pop_lvl_q, pop_lvl_d;

  logic               pend_q, pend_d;
  ppq_pkg::status_e   status_q, status_d;
  logic               pend_load;
  logic               pend_move;

  logic                              out_valid_q, out_valid_d;
  logic                              out_run_valid_q;
  logic [ppq_pkg::TASK_ID_W-1:0]     out_id_q;
  logic [ppq_pkg::PRIO_W-1:0]        out_prio_q;
  ppq_pkg::status_e                  out_status_q;

  logic [ID_BITS-1:0]            id_in;
  logic [ppq_pkg::TASK_ID_W-1:0] run_id_narrow;
  logic                          prio_ok;
  logic [LVL_W-1:0]              new_lvl;
  logic                          any_queued;
  logic [LVL_W-1:0]              top_lvl;

  logic               push_req;
  logic [LVL_W-1:0]   push_lvl;
  logic [ID_BITS-1:0] push_id;
  logic               push_full;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;

  // id kept in ID_BITS bits, widened or cut from the 8 bit field
  always_comb begin
    id_in         = '0;
    run_id_narrow = '0;
    for (int i = 0; i < ID_BITS && i < ppq_pkg::TASK_ID_W; i++) begin
      id_in[i]         = task_id_i[i];
      run_id_narrow[i] = run_id_q[i];
    end
  end

  assign prio_ok = ({1'b0, task_priority_i} < LEVELS_C);
  assign new_lvl = task_priority_i[LVL_W-1:0];

  // highest non-empty level
  always_comb begin
    any_queued = 1'b0;
    top_lvl    = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (cnt_q[l] != '0) begin
        any_queued = 1'b1;
        top_lvl    = LVL_W'(l);
      end
    end
  end

  always_comb begin
    run_valid_d = run_valid_q;
    run_id_d    = run_id_q;
    run_prio_d  = run_prio_q;
    pop_lvl_d   = pop_lvl_q;
    status_d    = status_q;
    pend_load   = 1'b0;
    push_req    = 1'b0;
    push_lvl    = new_lvl;
    push_id     = id_in;
    rd_en       = 1'b0;

    if (cmd_i.add) begin
      pend_load = 1'b1;
      status_d  = ppq_pkg::STAT_OK;
      if (!prio_ok) begin
        status_d = ppq_pkg::STAT_BAD_PRIO;
      end else if (!run_valid_q) begin
        run_valid_d = 1'b1;
        run_id_d    = id_in;
        run_prio_d  = new_lvl;
      end else if (task_priority_i > ppq_pkg::PRIO_W'(run_prio_q)) begin
        // preempted task goes back to the tail of its own level
        push_req   = 1'b1;
        push_lvl   = run_prio_q;
        push_id    = run_id_q;
        run_id_d   = id_in;
        run_prio_d = new_lvl;
      end else begin
        push_req = 1'b1;
      end
      if (push_req && push_full) begin
        status_d = ppq_pkg::STAT_FULL;
      end
    end else if (cmd_i.term) begin
      if (any_queued) begin
        rd_en     = 1'b1;
        pop_lvl_d = top_lvl;
      end else begin
        run_valid_d = 1'b0;
        run_id_d    = '0;
        run_prio_d  = '0;
        status_d    = ppq_pkg::STAT_OK;
        pend_load   = 1'b1;
      end
    end else if (cmd_i.pop_done) begin
      run_valid_d = 1'b1;
      run_id_d    = rdata_q;
      run_prio_d  = pop_lvl_q;
      status_d    = ppq_pkg::STAT_OK;
      pend_load   = 1'b1;
    end
  end

  assign push_full = (cnt_q[push_lvl] == FULL_C);
  assign wr_en     = push_req && !push_full;
  assign wr_addr   = ADDR_W'(push_lvl) * DEPTH_C + ADDR_W'(tail_q[push_lvl]);
  assign rd_addr   = ADDR_W'(top_lvl) * DEPTH_C + ADDR_W'(head_q[top_lvl]);

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      head_d[l] = head_q[l];
      tail_d[l] = tail_q[l];
      cnt_d[l]  = cnt_q[l];
    end
    if (wr_en) begin
      tail_d[push_lvl] = ptr_inc(tail_q[push_lvl]);
      cnt_d[push_lvl]  = cnt_q[push_lvl] + CNT_W'(1);
    end
    if (rd_en) begin
      head_d[top_lvl] = ptr_inc(head_q[top_lvl]);
      cnt_d[top_lvl]  = cnt_q[top_lvl] - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= push_id;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // pending result mirrors the running slot until it moves to the output register
  assign pend_move   = pend_q && (!out_valid_q || out_ready_i);
  assign pend_d      = pend_load ? 1'b1 : (pend_move ? 1'b0 : pend_q);
  assign out_valid_d = pend_move ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
      run_valid_q <= 1'b0;
      run_id_q    <= '0;
      run_prio_q  <= '0;
      pop_lvl_q   <= '0;
      pend_q      <= 1'b0;
      status_q    <= ppq_pkg::STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= head_d[l];
        tail_q[l] <= tail_d[l];
        cnt_q[l]  <= cnt_d[l];
      end
      run_valid_q <= run_valid_d;
      run_id_q    <= run_id_d;
      run_prio_q  <= run_prio_d;
      pop_lvl_q   <= pop_lvl_d;
      pend_q      <= pend_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      out_run_valid_q <= run_valid_q;
      out_id_q        <= run_id_narrow;
      out_prio_q      <= ppq_pkg::PRIO_W'(run_prio_q);
      out_status_q    <= status_q;
    end
  end

  assign stat_o.pend_free  = !pend_q || pend_move;
  assign stat_o.any_queued = any_queued;

  assign out_valid_o        = out_valid_q;
  assign running_valid_o    = out_run_valid_q;
  assign running_id_o       = out_id_q;
  assign running_priority_o = out_prio_q;
  assign status_o           = out_status_q;

endmodule

FILE: verif/preemptive_priority_ready_queues_core_test.sv
// testbench of the preemptive priority scheduler: directed table, random traffic, predictor
module preemptive_priority_ready_queues_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS       = ppq_pkg::LEVELS_DEF;
  localparam int QUEUE_DEPTH  = ppq_pkg::QUEUE_DEPTH_DEF;
  localparam int PRIO_W       = ppq_pkg::PRIO_W;
  localparam int ID_W         = ppq_pkg::TASK_ID_W;
  localparam int RANDOM_REQS  = 930;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRED_DEPTH   = 64;

  typedef struct packed {
    logic              on;
    logic [ID_W-1:0]   tid;
    logic [PRIO_W-1:0] lvl;
    ppq_pkg::status_e  status;
  } running_t;

  typedef struct {
    logic              act;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    bit                typed;
    running_t          want;
  } req_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // predictor state: ready queues and the running slot
  logic [ID_W-1:0]   ready_ids [LEVELS][QUEUE_DEPTH];
  int unsigned       ready_head [LEVELS];
  int unsigned       ready_cnt [LEVELS];
  logic              run_on;
  logic [ID_W-1:0]   run_tid;
  logic [PRIO_W-1:0] run_lvl;

  // expected results in request order
  running_t    pred_fifo [PRED_DEPTH];
  int unsigned pred_wr = 0;
  int unsigned pred_rd = 0;

  req_row_t plan [24];
  int       requests_sent;
  int       gap_max;
  int       stall_max;
  bit       failed;

  preemptive_priority_ready_queues_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit ready_push(input int lvl, input logic [ID_W-1:0] id);
    if (ready_cnt[lvl] >= QUEUE_DEPTH) begin
      return 1'b0;
    end
    ready_ids[lvl][(ready_head[lvl] + ready_cnt[lvl]) % QUEUE_DEPTH] = id;
    ready_cnt[lvl]++;
    return 1'b1;
  endfunction

  function automatic running_t predict_running(input logic act, input logic [PRIO_W-1:0] prio,
                                               input logic [ID_W-1:0] id);
    running_t r;
    r.status = ppq_pkg::STAT_OK;
    if (act == ppq_pkg::ACT_ADD) begin
      if (prio >= LEVELS) begin
        r.status = ppq_pkg::STAT_BAD_PRIO;
      end else if (!run_on) begin
        run_on  = 1'b1;
        run_tid = id;
        run_lvl = prio;
      end else if (prio > run_lvl) begin
        // preempted task goes back to the tail of its own level
        if (!ready_push(int'(run_lvl), run_tid)) r.status = ppq_pkg::STAT_FULL;
        run_tid = id;
        run_lvl = prio;
      end else if (!ready_push(int'(prio), id)) begin
        r.status = ppq_pkg::STAT_FULL;
      end
    end else begin
      run_on  = 1'b0;
      run_tid = '0;
      run_lvl = '0;
      for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
        if (!run_on && ready_cnt[lvl] != 0) begin
          run_tid         = ready_ids[lvl][ready_head[lvl]];
          ready_head[lvl] = (ready_head[lvl] + 1) % QUEUE_DEPTH;
          ready_cnt[lvl]--;
          run_lvl         = PRIO_W'(lvl);
          run_on          = 1'b1;
        end
      end
    end
    r.on  = run_on;
    r.tid = run_on ? run_tid : '0;
    r.lvl = run_on ? run_lvl : '0;
    return r;
  endfunction

  task automatic send_request(input logic act, input logic [PRIO_W-1:0] prio,
                              input logic [ID_W-1:0] id, input bit typed,
                              input running_t want);
    int       gap;
    running_t pred;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, id, prio};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pred = predict_running(act, prio, id);
    pred_fifo[pred_wr % PRED_DEPTH] = typed ? want : pred;
    pred_wr++;
    requests_sent++;
  endtask

  // result side: random stall before each result
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    running_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pred_wr == pred_rd) begin
        $error("result with no request outstanding: tdata %h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = pred_fifo[pred_rd % PRED_DEPTH];
        pred_rd++;
        if (m_axis_tdata[0] !== want.on) begin
          $error("running_valid: expected %0d, got %0d", want.on, m_axis_tdata[0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[8:1] !== want.tid) begin
          $error("running_id: expected %0d, got %0d", want.tid, m_axis_tdata[8:1]);
          failed = 1'b1;
        end
        if (m_axis_tdata[11:9] !== want.lvl) begin
          $error("running_priority: expected %0d, got %0d", want.lvl, m_axis_tdata[11:9]);
          failed = 1'b1;
        end
        if (m_axis_tdata[13:12] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[13:12]);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int n;
    int lvl;
    failed        = 1'b0;
    requests_sent = 0;
    gap_max       = 17;
    stall_max     = 17;
    run_on        = 1'b0;
    run_tid       = '0;
    run_lvl       = '0;
    for (int i = 0; i < LEVELS; i++) begin
      ready_head[i] = 0;
      ready_cnt[i]  = 0;
    end

    // hand-checked rows carry their result, the rest follow the predictor
    plan = '{
      '{ppq_pkg::ACT_TERM, 3'd7, 8'hFF, 1'b1, '{1'b0, 8'h00, 3'd0, ppq_pkg::STAT_OK}},
      '{ppq_pkg::ACT_ADD,  3'd5, 8'h11, 1'b1, '{1'b0, 8'h00, 3'd0, ppq_pkg::STAT_BAD_PRIO}},
      '{ppq_pkg::ACT_ADD,  3'd7, 8'hFF, 1'b1, '{1'b0, 8'h00, 3'd0, ppq_pkg::STAT_BAD_PRIO}},
      '{ppq_pkg::ACT_ADD,  3'd0, 8'h00, 1'b1, '{1'b1, 8'h00, 3'd0, ppq_pkg::STAT_OK}},
      '{ppq_pkg::ACT_ADD,  3'd0, 8'hFF, 1'b1, '{1'b1, 8'h00, 3'd0, ppq_pkg::STAT_OK}},
      '{ppq_pkg::ACT_ADD,  3'd4, 8'hA5, 1'b0, '0},
      '{ppq_pkg::ACT_ADD,  3'd2, 8'h5A, 1'b0, '0},
      '{ppq_pkg::ACT_ADD,  3'd4, 8'h3C, 1'b0, '0},
      '{ppq_pkg::ACT_ADD,  3'd6, 8'h77, 1'b1, '{1'b1, 8'hA5, 3'd4, ppq_pkg::STAT_BAD_PRIO}},
      '{ppq_pkg::ACT_ADD,  3'd3, 8'h81, 1'b0, '0},
      '{ppq_pkg::ACT_ADD,  3'd1, 8'h42, 1'b0, '0},
      '{ppq_pkg::ACT_TERM, 3'd0, 8'h00, 1'b0, '0},
      '{ppq_pkg::ACT_TERM, 3'd7, 8'hFF, 1'b0, '0},
      '{ppq_pkg::ACT_TERM, 3'd2, 8'h55, 1'b0, '0},
      '{ppq_pkg::ACT_ADD,  3'd2, 8'h99, 1'b0, '0},
      '{ppq_pkg::ACT_ADD,  3'd3, 8'hC3, 1'b0, '0},
      '{ppq_pkg::ACT_TERM, 3'd0, 8'h00, 1'b0, '0},
      '{ppq_pkg::ACT_TERM, 3'd0, 8'h00, 1'b0, '0},
      '{ppq_pkg::ACT_TERM, 3'd0, 8'h00, 1'b0, '0},
      '{ppq_pkg::ACT_TERM, 3'd0, 8'h00, 1'b0, '0},
      '{ppq_pkg::ACT_TERM, 3'd0, 8'h00, 1'b0, '0},
      '{ppq_pkg::ACT_TERM, 3'd0, 8'h00, 1'b1, '{1'b0, 8'h00, 3'd0, ppq_pkg::STAT_OK}},
      '{ppq_pkg::ACT_TERM, 3'd5, 8'h3C, 1'b1, '{1'b0, 8'h00, 3'd0, ppq_pkg::STAT_OK}},
      '{ppq_pkg::ACT_ADD,  3'd1, 8'h01, 1'b1, '{1'b1, 8'h01, 3'd1, ppq_pkg::STAT_OK}}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send_request(plan[i].act, plan[i].prio, plan[i].id, plan[i].typed, plan[i].want);
    end

    while (requests_sent < RANDOM_REQS) begin
      gap_max   = ($urandom_range(0, 9) < 3) ? 0 : 17;
      stall_max = ($urandom_range(0, 9) < 3) ? 0 : 17;
      case ($urandom_range(0, 3))
        0, 1: begin
          // mixed adds and terminates, some with out-of-range priority
          n = $urandom_range(10, 40);
          repeat (n) begin
            if ($urandom_range(0, 9) < 4) begin
              send_request(ppq_pkg::ACT_TERM, PRIO_W'($urandom_range(0, 7)),
                           ID_W'($urandom_range(0, 255)), 1'b0, '0);
            end else if ($urandom_range(0, 9) == 0) begin
              send_request(ppq_pkg::ACT_ADD, PRIO_W'($urandom_range(LEVELS, 7)),
                           ID_W'($urandom_range(0, 255)), 1'b0, '0);
            end else begin
              send_request(ppq_pkg::ACT_ADD, PRIO_W'($urandom_range(0, LEVELS - 1)),
                           ID_W'($urandom_range(0, 255)), 1'b0, '0);
            end
          end
        end
        2: begin
          // overfill one level, then maybe preempt into the full queue
          lvl = $urandom_range(0, LEVELS - 1);
          n   = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 5);
          repeat (n) begin
            send_request(ppq_pkg::ACT_ADD, PRIO_W'(lvl), ID_W'($urandom_range(0, 255)),
                         1'b0, '0);
          end
          if (lvl < LEVELS - 1 && $urandom_range(0, 1) == 1) begin
            send_request(ppq_pkg::ACT_ADD, PRIO_W'($urandom_range(lvl + 1, LEVELS - 1)),
                         ID_W'($urandom_range(0, 255)), 1'b0, '0);
          end
        end
        default: begin
          // drain, often past empty
          n = $urandom_range(5, 40);
          repeat (n) begin
            send_request(ppq_pkg::ACT_TERM, PRIO_W'($urandom_range(0, 7)),
                         ID_W'($urandom_range(0, 255)), 1'b0, '0);
          end
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;

    while (pred_rd != pred_wr) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!failed && pred_rd == pred_wr) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
